// ===== hdl/conv2d_single_channel_stream_top_assert.svh =====
// Assertion macros for the 2-D convolution stream block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef CONV2D_SINGLE_CHANNEL_STREAM_TOP_ASSERT_SVH
`define CONV2D_SINGLE_CHANNEL_STREAM_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// checked on every clock edge outside reset
`define C2D_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every clock edge, reset included
`define C2D_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define C2D_ASSERT(name, prop, msg)
`define C2D_ASSERT_RST(name, prop, msg)
`endif
`endif

// ===== hdl/c2d_pkg.sv =====
// Shared types and constants for the 2-D convolution stream block.
// No dependencies.
`timescale 1ns / 1ps
package c2d_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int KDIM_W     = 5;   // kernel dimension, clamped to the kernel store size
  localparam int RES_W      = 40;
  localparam int IDX_W      = 10;

  localparam logic OP_TAP    = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_H    = 3'd0,
    CFG_IMG_W    = 3'd1,
    CFG_KER_H    = 3'd2,
    CFG_KER_W    = 3'd3,
    CFG_PAD_MODE = 3'd4,
    CFG_PAD_SIZE = 3'd5,
    CFG_STRIDE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PAD_VALID  = 2'd0,
    PAD_SAME   = 2'd1,
    PAD_CUSTOM = 2'd2
  } pad_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINE,
    ST_MAC
  } state_e;

  typedef struct packed {
    logic              start;
    logic [KDIM_W-1:0] kh;
    logic [KDIM_W-1:0] kw;
  } mac_ctrl_t;

endpackage

// ===== hdl/c2d_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module c2d_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/c2d_mac.sv =====
// Kernel store, window column ring and shared multiply-accumulate sequencer.
// Depends on c2d_pkg and c2d_ram.
`timescale 1ns / 1ps
module c2d_mac
  import c2d_pkg::*;
#(
  parameter int  MK = 8,
  parameter int  SB = 16,
  localparam int KD = MK * MK,
  localparam int KA = (KD > 1) ? $clog2(KD) : 1,
  localparam int RA = (MK > 1) ? $clog2(MK) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tap_we_i,
  input  logic [KA-1:0]    tap_addr_i,
  input  logic [SB-1:0]    tap_data_i,
  input  logic             ring_we_i,
  input  logic [MK*SB-1:0] ring_data_i,
  input  mac_ctrl_t        ctrl_i,
  output logic             busy_o,
  output logic [RES_W-1:0] acc_o
);

  logic [KD-1:0]     kvld_q;
  logic [MK-1:0]     rvld_q;
  logic [RA-1:0]     wp_q, cur_q, wp_nx;
  logic              run_q, p1_q, p2_q;
  logic [KDIM_W-1:0] i_q, j_q, kh_q, kw_q, elem_q;
  logic              kv_q, rv_q;
  logic [KA-1:0]     kaddr;
  logic [RA+1:0]     rsum;
  logic [RA-1:0]     raddr;
  logic [SB-1:0]     kern_rd;
  logic [MK*SB-1:0]  ring_rd;
  logic signed [SB-1:0]    k_op, w_op;
  logic signed [2*SB-1:0]  prod_q;
  logic [RES_W-1:0]  acc_q;

  // kernel tap for step (i, j); window column of age kw-1-j in the ring
  assign kaddr = KA'(32'(i_q) * MK + 32'(j_q));
  assign rsum  = (RA+2)'(cur_q) + (RA+2)'(MK) + (RA+2)'(j_q) + (RA+2)'(1) - (RA+2)'(kw_q);
  assign raddr = (rsum >= (RA+2)'(MK)) ? RA'(rsum - (RA+2)'(MK)) : RA'(rsum);
  assign wp_nx = (wp_q == RA'(MK - 1)) ? '0 : wp_q + 1'b1;

  c2d_ram #(.WIDTH(SB), .DEPTH(KD)) u_kernel (
    .clk_i   (clk_i),
    .we_i    (tap_we_i),
    .waddr_i (tap_addr_i),
    .wdata_i (tap_data_i),
    .raddr_i (kaddr),
    .rdata_o (kern_rd)
  );

  c2d_ram #(.WIDTH(MK*SB), .DEPTH(MK)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we_i),
    .waddr_i (wp_q),
    .wdata_i (ring_data_i),
    .raddr_i (raddr),
    .rdata_o (ring_rd)
  );

  // valid bits stand in for the zero reset of both stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kvld_q <= '0;
      rvld_q <= '0;
      wp_q   <= '0;
      cur_q  <= '0;
    end else begin
      if (tap_we_i) begin
        kvld_q[tap_addr_i] <= 1'b1;
      end
      if (ring_we_i) begin
        rvld_q[wp_q] <= 1'b1;
        cur_q        <= wp_q;
        wp_q         <= wp_nx;
      end
    end
  end

  // step sequencer and pipeline flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      p1_q  <= 1'b0;
      p2_q  <= 1'b0;
      i_q   <= '0;
      j_q   <= '0;
      kh_q  <= KDIM_W'(1);
      kw_q  <= KDIM_W'(1);
    end else begin
      p1_q <= run_q;
      p2_q <= p1_q;
      if (ctrl_i.start) begin
        run_q <= 1'b1;
        i_q   <= '0;
        j_q   <= '0;
        kh_q  <= ctrl_i.kh;
        kw_q  <= ctrl_i.kw;
      end else if (run_q) begin
        if (j_q == kw_q - 1'b1) begin
          j_q <= '0;
          if (i_q == kh_q - 1'b1) begin
            run_q <= 1'b0;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
    end
  end

  // operand select once read data is back
  assign k_op = kv_q ? $signed(kern_rd) : '0;
  assign w_op = rv_q ? $signed(ring_rd[elem_q*SB +: SB]) : '0;

  // read tags, product and accumulator
  always_ff @(posedge clk_i) begin
    kv_q   <= kvld_q[kaddr];
    rv_q   <= rvld_q[raddr];
    elem_q <= kh_q - 1'b1 - i_q;
    prod_q <= k_op * w_op;
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (p2_q) begin
      acc_q <= acc_q + RES_W'(prod_q);
    end
  end

  assign busy_o = run_q | p1_q | p2_q;
  assign acc_o  = acc_q;

endmodule

// ===== hdl/conv2d_single_channel_stream_top.sv =====
// Top level of the streaming single-channel 2-D convolution block.
// Depends on c2d_pkg, c2d_ram, c2d_mac and the assertion macro header.
//
// Usage:
//  - cfg channel: write registers 0..6 (height, width, kernel height/width, padding
//    mode, pad size, stride) while the block is idle; any write to them restarts the image.
//  - s_axis: tuser = 0 loads one kernel tap, tuser = 1 carries one padded image
//    position in raster order; border positions are forced to zero internally.
//  - m_axis: one transaction per window origin on the stride grid, with its output
//    row and column; tlast marks the final output of the image.
//  - Work per item: a tap load leaves the block idle. A sample goes through a line store
//    read, then line and window write-back; a sample that completes a window adds
//    a pass over the kernel on the shared multiply-accumulate plus its pipeline
//    drain, and no new item is taken until that is done.
//  - The line store holds MAX_KERNEL-1 past rows per column, one memory word per
//    column; it has no reset and needs no clearing pass. Kernel taps and the window
//    read as zero after reset.
//  - A finished result waits in the output register while the next items are taken;
//    only a second result stalls, at the end of its accumulation.
`timescale 1ns / 1ps
`include "conv2d_single_channel_stream_top_assert.svh"
module conv2d_single_channel_stream_top
  import c2d_pkg::*;
#(
  parameter int MAX_KERNEL  = 8,
  parameter int MAX_LINE    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: tap_row[2:0], tap_col[5:3], value[6 +: SAMPLE_BITS], zero fill
  input  logic [((6+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: operation
  input  logic                  s_axis_tuser,
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: result[39:0], out_row[49:40], out_col[59:50], zero fill
  output logic [63:0]           m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int LROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int LA    = $clog2(MAX_LINE);
  localparam int COL_W = $clog2(MAX_LINE + 1);
  localparam int ROW_W = 12;
  localparam int GW    = 14;
  localparam int KD    = MAX_KERNEL * MAX_KERNEL;
  localparam int KA    = (KD > 1) ? $clog2(KD) : 1;
  localparam int SB    = SAMPLE_BITS;

  state_e state_q, state_d;

  // configuration registers
  logic [10:0] img_h_q, img_w_q;
  logic [3:0]  ker_h_q, ker_w_q, stride_q;
  logic [1:0]  pad_mode_q;
  logic [2:0]  pad_size_q;

  // image position, stride phases and output counters
  logic [ROW_W-1:0] pos_row_q, pos_row_d;
  logic [COL_W-1:0] pos_col_q, pos_col_d;
  logic [3:0]       rph_q, rph_d, cph_q, cph_d;
  logic [IDX_W-1:0] nrow_q, nrow_d, ncol_q, ncol_d;

  // held sample and pending result metadata
  logic [LA-1:0]    smp_c_q;
  logic [SB-1:0]    smp_v_q;
  logic             emit_q;
  logic [IDX_W-1:0] res_row_q, res_col_q;
  logic             res_last_q;

  // output register
  logic             m_vld_q;
  logic [RES_W-1:0] m_res_q;
  logic [IDX_W-1:0] m_row_q, m_col_q;
  logic             m_last_q;

  logic [2:0]        pad;
  logic [KDIM_W-1:0] kh, kw;
  logic [3:0]        s;
  logic [GW-1:0]     ph, pw_raw, pw, g_r, g_c;
  logic              empty, border, on_grid, last_r, last_c, col_wrap;
  logic [2:0]        tap_row, tap_col;
  logic [SB-1:0]     value;
  logic              in_acc, smp_acc, tap_we, cfg_we, line_we, out_load;
  logic [KA-1:0]     tap_addr;
  logic [MAX_KERNEL*SB-1:0] colv;
  logic [LROWS*SB-1:0]      line_rd, line_wd;
  logic              mac_busy;
  logic [RES_W-1:0]  mac_acc;
  mac_ctrl_t         mac_ctrl;

  // input unpacking
  assign tap_row = s_axis_tdata[2:0];
  assign tap_col = s_axis_tdata[5:3];
  assign value   = s_axis_tdata[6 +: SB];

  // effective geometry
  always_comb begin
    case (pad_mode_q)
      PAD_SAME:   pad = 3'd1;
      PAD_CUSTOM: pad = pad_size_q;
      default:    pad = 3'd0;
    endcase
    kh = (ker_h_q == '0) ? KDIM_W'(1) :
         (32'(ker_h_q) > MAX_KERNEL) ? KDIM_W'(MAX_KERNEL) : KDIM_W'(ker_h_q);
    kw = (ker_w_q == '0) ? KDIM_W'(1) :
         (32'(ker_w_q) > MAX_KERNEL) ? KDIM_W'(MAX_KERNEL) : KDIM_W'(ker_w_q);
    s      = (stride_q == '0) ? 4'd1 : stride_q;
    ph     = GW'(img_h_q) + GW'(pad) + GW'(pad);
    pw_raw = GW'(img_w_q) + GW'(pad) + GW'(pad);
    pw     = (pw_raw > GW'(MAX_LINE)) ? GW'(MAX_LINE) : pw_raw;
    g_r    = GW'(pos_row_q);
    g_c    = GW'(pos_col_q);
  end

  // per-sample decisions, all from the position counters
  assign empty    = (ph == '0) || (pw == '0);
  assign border   = (g_r < GW'(pad)) || (g_r >= GW'(pad) + GW'(img_h_q)) ||
                    (g_c < GW'(pad)) || (g_c >= GW'(pad) + GW'(img_w_q));
  assign on_grid  = (g_r + 1'b1 >= GW'(kh)) && (g_c + 1'b1 >= GW'(kw)) &&
                    (rph_q == '0) && (cph_q == '0);
  assign last_r   = (g_r + 1'b1 + GW'(s)) > ph;
  assign last_c   = (g_c + 1'b1 + GW'(s)) > pw;
  assign col_wrap = (g_c + 1'b1) >= pw;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign smp_acc = in_acc && (s_axis_tuser == OP_SAMPLE) && !empty;
  assign tap_we  = in_acc && (s_axis_tuser == OP_TAP) &&
                   (32'(tap_row) < MAX_KERNEL) && (32'(tap_col) < MAX_KERNEL);
  assign tap_addr = KA'(32'(tap_row) * MAX_KERNEL + 32'(tap_col));
  assign cfg_we  = cfg_valid_i && cfg_ready_o;

  // position, phase and output counter update
  always_comb begin
    pos_row_d = pos_row_q;
    pos_col_d = pos_col_q;
    rph_d     = rph_q;
    cph_d     = cph_q;
    nrow_d    = nrow_q;
    ncol_d    = ncol_q;
    if (smp_acc) begin
      if (on_grid) begin
        if (last_c) begin
          ncol_d = '0;
          nrow_d = last_r ? '0 : nrow_q + 1'b1;
        end else begin
          ncol_d = ncol_q + 1'b1;
        end
      end
      if (col_wrap) begin
        pos_col_d = '0;
        cph_d     = '0;
        pos_row_d = pos_row_q + 1'b1;
        if (g_r + 1'b1 >= GW'(kh)) begin
          rph_d = (rph_q + 1'b1 == s) ? '0 : rph_q + 1'b1;
        end else begin
          rph_d = '0;
        end
        if (g_r + 1'b1 >= ph) begin
          pos_row_d = '0;
          rph_d     = '0;
          nrow_d    = '0;
          ncol_d    = '0;
        end
      end else begin
        pos_col_d = pos_col_q + 1'b1;
        if (g_c + 1'b1 >= GW'(kw)) begin
          cph_d = (cph_q + 1'b1 == s) ? '0 : cph_q + 1'b1;
        end else begin
          cph_d = '0;
        end
      end
    end
    // a register write restarts the image
    if (cfg_we && (cfg_index_i <= CFG_STRIDE)) begin
      pos_row_d = '0;
      pos_col_d = '0;
      rph_d     = '0;
      cph_d     = '0;
      nrow_d    = '0;
      ncol_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_row_q  <= '0;
      pos_col_q  <= '0;
      rph_q      <= '0;
      cph_q      <= '0;
      nrow_q     <= '0;
      ncol_q     <= '0;
      img_h_q    <= 11'd8;
      img_w_q    <= 11'd8;
      ker_h_q    <= 4'd3;
      ker_w_q    <= 4'd3;
      pad_mode_q <= PAD_VALID;
      pad_size_q <= 3'd1;
      stride_q   <= 4'd1;
    end else begin
      pos_row_q <= pos_row_d;
      pos_col_q <= pos_col_d;
      rph_q     <= rph_d;
      cph_q     <= cph_d;
      nrow_q    <= nrow_d;
      ncol_q    <= ncol_d;
      if (cfg_we) begin
        unique case (cfg_index_i)
          CFG_IMG_H:    img_h_q    <= cfg_data_i;
          CFG_IMG_W:    img_w_q    <= cfg_data_i;
          CFG_KER_H:    ker_h_q    <= cfg_data_i[3:0];
          CFG_KER_W:    ker_w_q    <= cfg_data_i[3:0];
          CFG_PAD_MODE: pad_mode_q <= cfg_data_i[1:0];
          CFG_PAD_SIZE: pad_size_q <= cfg_data_i[2:0];
          CFG_STRIDE:   stride_q   <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // hold the accepted sample for the write-back cycle
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      smp_c_q    <= pos_col_q[LA-1:0];
      smp_v_q    <= border ? '0 : value;
      emit_q     <= on_grid;
      res_row_q  <= nrow_q;
      res_col_q  <= ncol_q;
      res_last_q <= on_grid && last_r && last_c;
    end
  end

  // column vector: newest sample first, then the stored rows above it
  always_comb begin
    for (int k = 0; k < MAX_KERNEL; k++) begin
      colv[k*SB +: SB] = (k == 0) ? smp_v_q : line_rd[((k > 0) ? k - 1 : 0)*SB +: SB];
    end
    for (int k = 0; k < LROWS; k++) begin
      line_wd[k*SB +: SB] = colv[k*SB +: SB];
    end
  end

  assign line_we = (state_q == ST_LINE);

  c2d_ram #(.WIDTH(LROWS*SB), .DEPTH(MAX_LINE)) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (smp_c_q),
    .wdata_i (line_wd),
    .raddr_i (pos_col_q[LA-1:0]),
    .rdata_o (line_rd)
  );

  assign mac_ctrl = '{start: line_we && emit_q, kh: kh, kw: kw};

  c2d_mac #(.MK(MAX_KERNEL), .SB(SB)) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tap_we_i    (tap_we),
    .tap_addr_i  (tap_addr),
    .tap_data_i  (value),
    .ring_we_i   (line_we),
    .ring_data_i (colv),
    .ctrl_i      (mac_ctrl),
    .busy_o      (mac_busy),
    .acc_o       (mac_acc)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          state_d = ST_LINE;
        end
      end
      ST_LINE: begin
        state_d = emit_q ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        if (!mac_busy && (!m_vld_q || m_axis_tready)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      m_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_res_q  <= mac_acc;
      m_row_q  <= res_row_q;
      m_col_q  <= res_col_q;
      m_last_q <= res_last_q;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {4'b0, m_col_q, m_row_q, m_res_q};
  assign m_axis_tlast  = m_last_q;

  `C2D_ASSERT(a_no_accept_busy, s_axis_tready |-> !mac_busy, "item taken during accumulation")
  `C2D_ASSERT(a_load_free, out_load |-> (!m_vld_q || m_axis_tready), "result overwritten")
  `C2D_ASSERT(a_cfg_restart, (cfg_valid_i && cfg_index_i <= CFG_STRIDE) |=> (pos_row_q == '0 && pos_col_q == '0), "config write did not restart")
  `C2D_ASSERT_RST(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "output valid in reset")

endmodule
